// ===== rtl/pps_pkg.sv =====
package pps_pkg;

    localparam int MAX_SLICE_GROUPS = 8;
    localparam int MAX_CODE_BITS    = 32;
    localparam int MAP_UNIT_BITS    = 18;

    localparam int CODE_W = 5;
    localparam int IDX_W  = 18;
    localparam int VAL_W  = 33;
    localparam int ST_W   = 3;
    localparam int LZ_W   = 6;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [ST_W-1:0] ST_GROUPS    = 3'd2;
    localparam logic [ST_W-1:0] ST_MAP_TYPE  = 3'd3;
    localparam logic [ST_W-1:0] ST_TRUNC     = 3'd4;
    localparam logic [ST_W-1:0] ST_TRAILING  = 3'd5;
    localparam logic [ST_W-1:0] ST_UNSUPPORT = 3'd6;

    localparam logic [CODE_W-1:0] POS_NUM_GROUPS   = 5'd4;
    localparam logic [CODE_W-1:0] POS_MAP_TYPE     = 5'd5;
    localparam logic [CODE_W-1:0] POS_RUN_LENGTH   = 5'd6;
    localparam logic [CODE_W-1:0] POS_TOP_LEFT     = 5'd7;
    localparam logic [CODE_W-1:0] POS_BOTTOM_RIGHT = 5'd8;
    localparam logic [CODE_W-1:0] POS_CHANGE_DIR   = 5'd9;
    localparam logic [CODE_W-1:0] POS_CHANGE_RATE  = 5'd10;
    localparam logic [CODE_W-1:0] POS_PIC_SIZE     = 5'd11;
    localparam logic [CODE_W-1:0] POS_GROUP_ID     = 5'd12;
    localparam logic [CODE_W-1:0] POS_NUM_REF_L0   = 5'd13;
    localparam logic [CODE_W-1:0] POS_TRANSFORM    = 5'd23;
    localparam logic [CODE_W-1:0] POS_SCALING_MTX  = 5'd24;
    localparam logic [CODE_W-1:0] POS_SCALING_LIST = 5'd25;
    localparam logic [CODE_W-1:0] POS_SECOND_QP    = 5'd26;
    localparam logic [CODE_W-1:0] POS_END          = 5'd27;

    localparam logic [2:0] K_UE = 3'd0;
    localparam logic [2:0] K_SE = 3'd1;
    localparam logic [2:0] K_U1 = 3'd2;
    localparam logic [2:0] K_U2 = 3'd3;
    localparam logic [2:0] K_UV = 3'd4;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
        logic              done;
        logic [ST_W-1:0]   status;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       bit_en;
        logic [2:0] bit_sel;
        logic       is_stop;
        logic       finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic    emit;
        t_result res;
        logic    halted;
    } t_stat;

    function automatic logic [2:0] kind_of(input logic [CODE_W-1:0] p);
        logic [2:0] k;
        k = K_U1;
        case (p)
            5'd0, 5'd1, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd10, 5'd11,
            5'd13, 5'd14: k = K_UE;
            5'd12: k = K_UV;
            5'd16: k = K_U2;
            5'd17, 5'd18, 5'd19, 5'd26: k = K_SE;
            default: k = K_U1;
        endcase
        return k;
    endfunction

    function automatic logic [CODE_W-1:0] after_map_type(input logic [2:0] t);
        logic [CODE_W-1:0] p;
        case (t)
            3'd0: p = POS_RUN_LENGTH;
            3'd1: p = POS_NUM_REF_L0;
            3'd2: p = POS_TOP_LEFT;
            3'd6: p = POS_PIC_SIZE;
            default: p = POS_CHANGE_DIR;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] id_bits(input logic [2:0] gm1);
        logic [1:0] b;
        if (gm1 >= 3'd4) b = 2'd3;
        else if (gm1 >= 3'd2) b = 2'd2;
        else b = 2'd1;
        return b;
    endfunction

endpackage

// ===== rtl/pps_stream_if.sv =====
interface pps_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pps_header_syntax_parser_unit.sv =====
// channel  | dir | payload                                        | handshake
// in_if    | in  | data_byte[7:0], final_byte                     | valid/ready
// out_if   | out | element_code, group_index, element_value,      | valid/ready
//          |     | done_res, status, last_of_run                  |
// cfg      | in  | i_cfg_wdata[1:0] (chroma_format)               | i_cfg_we
// One RBSP bit is decoded per cycle while the output is not stalled; a byte
// takes the accept step, the serial bit walk of the controller and, on the final byte, a finish step.
// A result passes a one-deep hold stage and the output register; the last of a run may skip the hold stage.
// A stalled output stops the bit walk; no result is dropped.
// Reset (synchronous, active low) re-arms the parse and sets chroma_format to 1.
module pps_header_syntax_parser_unit
    import pps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    pps_stream_if.sink   in_if,
    pps_stream_if.source out_if
);

    logic [1:0] r_chroma;
    t_cmd       cmd;
    t_stat      stat;
    t_result    ores;
    logic       olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_chroma <= 2'd1;
        else if (i_cfg_we) r_chroma <= i_cfg_wdata;
    end

    pps_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_if.valid),
        .o_in_ready   (in_if.ready),
        .i_final_byte (in_if.data.final_byte),
        .i_data_byte  (in_if.data.data_byte),
        .i_out_ready  (out_if.ready),
        .o_out_valid  (out_if.valid),
        .o_out        (ores),
        .o_out_last   (olast),
        .o_cmd        (cmd),
        .i_stat       (stat)
    );

    pps_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_chroma_format (r_chroma),
        .i_data_byte     (in_if.data.data_byte),
        .i_final_byte    (in_if.data.final_byte),
        .i_cmd           (cmd),
        .o_stat          (stat)
    );

    assign out_if.data.element_code  = ores.code;
    assign out_if.data.group_index   = ores.index;
    assign out_if.data.element_value = ores.value;
    assign out_if.data.done_res      = ores.done;
    assign out_if.data.status        = ores.status;
    assign out_if.data.last_of_run   = olast;

`ifndef SYNTHESIS
    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.bit_en || cmd.finish) |-> !in_if.ready)
        else $error("input accepted during bit walk");
    a_error_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_if.valid && out_if.data.status != ST_OK) |-> out_if.data.done_res)
        else $error("error result without done");
    a_finish_not_with_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.bit_en && cmd.finish))
        else $error("finish and bit step together");
`endif

endmodule

// ===== rtl/pps_datapath.sv =====
module pps_datapath
    import pps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_chroma_format,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    input  t_cmd        i_cmd,
    output t_stat       o_stat
);

    logic [7:0]          r_byte;
    logic                r_fin;
    logic [CODE_W-1:0]   r_pos, n_pos;
    logic [LZ_W-1:0]     r_lz, n_lz;
    logic [VAL_W-1:0]    r_acc, n_acc;
    logic [IDX_W-1:0]    r_loop, n_loop;
    logic [2:0]          r_gm1, n_gm1;
    logic [2:0]          r_map, n_map;
    logic [IDX_W-1:0]    r_units, n_units;
    logic                r_e8, n_e8;
    logic                r_halt, n_halt;
    logic                r_started, n_started;
    logic                r_suffix, n_suffix;
    logic [LZ_W-1:0]     r_left, n_left;

    logic                b;
    logic [2:0]          kind;
    logic                cpl;
    logic [VAL_W-1:0]    cpl_k;
    logic [VAL_W-1:0]    v;
    logic [LZ_W-1:0]     left0;
    logic [LZ_W-1:0]     left1;
    logic [VAL_W-1:0]    acc1;
    logic [VAL_W-1:0]    pow_m1;
    logic [3:0]          n_lists;
    logic [IDX_W-1:0]    loop_inc;
    logic [IDX_W-1:0]    cur_idx;
    t_result             res;
    logic                emit;

    always_comb begin
        b    = r_byte[i_cmd.bit_sel];
        kind = kind_of(r_pos);
        case (r_pos)
            POS_RUN_LENGTH, POS_TOP_LEFT, POS_BOTTOM_RIGHT, POS_GROUP_ID,
            POS_SCALING_LIST: cur_idx = r_loop;
            default: cur_idx = '0;
        endcase
        loop_inc = r_loop + 1'b1;
        pow_m1   = (VAL_W'(1) << r_lz) - 1'b1;
        n_lists  = 4'd6 + ((i_chroma_format != 2'd3) ? 4'd2 : 4'd6) * {3'd0, r_e8};
    end

    always_comb begin
        n_pos     = r_pos;
        n_lz      = r_lz;
        n_acc     = r_acc;
        n_loop    = r_loop;
        n_gm1     = r_gm1;
        n_map     = r_map;
        n_units   = r_units;
        n_e8      = r_e8;
        n_halt    = r_halt;
        n_started = r_started;
        n_suffix  = r_suffix;
        n_left    = r_left;
        emit      = 1'b0;
        res       = '0;
        cpl       = 1'b0;
        cpl_k     = '0;
        v         = '0;
        left0     = '0;
        left1     = '0;
        acc1      = '0;

        if (i_cmd.bit_en && !r_halt) begin
            if (r_pos >= POS_END) begin
                emit       = 1'b1;
                res.code   = POS_END;
                res.done   = 1'b1;
                res.status = (b && i_cmd.is_stop) ? ST_OK : ST_TRAILING;
                n_halt     = 1'b1;
            end else if (r_pos == POS_TRANSFORM && !r_started && i_cmd.is_stop) begin
                emit     = 1'b1;
                res.code = POS_END;
                res.done = 1'b1;
                n_halt   = 1'b1;
            end else begin
                case (kind)
                    K_U1: left0 = LZ_W'(1);
                    K_U2: left0 = LZ_W'(2);
                    K_UV: left0 = LZ_W'(id_bits(r_gm1));
                    default: left0 = '0;
                endcase
                n_started = 1'b1;
                if (kind == K_U1 || kind == K_U2 || kind == K_UV) begin
                    acc1  = r_started ? {r_acc[VAL_W-2:0], b} : {{(VAL_W-1){1'b0}}, b};
                    left1 = (r_started ? r_left : left0) - 1'b1;
                    n_acc  = acc1;
                    n_left = left1;
                    if (left1 == '0) begin
                        cpl   = 1'b1;
                        cpl_k = acc1;
                    end
                end else if (!r_started || !r_suffix) begin
                    if (!b) begin
                        if (r_started && (r_lz + 1'b1 >= LZ_W'(MAX_CODE_BITS))) begin
                            emit       = 1'b1;
                            res.code   = r_pos;
                            res.index  = cur_idx;
                            res.done   = 1'b1;
                            res.status = ST_OVERFLOW;
                            n_halt     = 1'b1;
                        end else begin
                            n_lz     = r_started ? r_lz + 1'b1 : LZ_W'(1);
                            n_suffix = 1'b0;
                        end
                    end else if (!r_started || r_lz == '0) begin
                        cpl   = 1'b1;
                        cpl_k = '0;
                    end else begin
                        n_suffix = 1'b1;
                        n_left   = r_lz;
                        n_acc    = '0;
                    end
                end else begin
                    acc1   = {r_acc[VAL_W-2:0], b};
                    left1  = r_left - 1'b1;
                    n_acc  = acc1;
                    n_left = left1;
                    if (left1 == '0) begin
                        cpl   = 1'b1;
                        cpl_k = pow_m1 + acc1;
                    end
                end
            end
        end

        if (cpl) begin
            n_started = 1'b0;
            n_suffix  = 1'b0;
            n_lz      = '0;
            n_acc     = '0;
            if (kind == K_SE)
                v = cpl_k[0] ? ((cpl_k + 1'b1) >> 1) : (VAL_W'(0) - (cpl_k >> 1));
            else
                v = cpl_k;
            emit       = 1'b1;
            res.code   = r_pos;
            res.index  = cur_idx;
            res.value  = v;
            case (r_pos)
                POS_NUM_GROUPS: begin
                    if (v > VAL_W'(MAX_SLICE_GROUPS - 1)) begin
                        res.done = 1'b1; res.status = ST_GROUPS; n_halt = 1'b1;
                    end else begin
                        n_gm1 = v[2:0];
                        n_pos = (v[2:0] != 3'd0) ? POS_MAP_TYPE : POS_NUM_REF_L0;
                    end
                end
                POS_MAP_TYPE: begin
                    if (v > VAL_W'(6)) begin
                        res.done = 1'b1; res.status = ST_MAP_TYPE; n_halt = 1'b1;
                    end else begin
                        n_map  = v[2:0];
                        n_loop = '0;
                        n_pos  = after_map_type(v[2:0]);
                    end
                end
                POS_RUN_LENGTH, POS_BOTTOM_RIGHT: begin
                    n_loop = loop_inc;
                    if (loop_inc > IDX_W'(r_gm1)) n_pos = POS_NUM_REF_L0;
                    else n_pos = (r_pos == POS_RUN_LENGTH) ? POS_RUN_LENGTH : POS_TOP_LEFT;
                end
                POS_CHANGE_RATE: n_pos = POS_NUM_REF_L0;
                POS_PIC_SIZE: begin
                    if (v > VAL_W'((1 << MAP_UNIT_BITS) - 1)) begin
                        res.done = 1'b1; res.status = ST_OVERFLOW; n_halt = 1'b1;
                    end else begin
                        n_units = v[IDX_W-1:0];
                        n_loop  = '0;
                        n_pos   = POS_GROUP_ID;
                    end
                end
                POS_GROUP_ID: begin
                    n_loop = loop_inc;
                    n_pos  = (loop_inc > r_units) ? POS_NUM_REF_L0 : POS_GROUP_ID;
                end
                POS_TRANSFORM: begin
                    n_e8  = v[0];
                    n_pos = POS_SCALING_MTX;
                end
                POS_SCALING_MTX: begin
                    n_loop = '0;
                    n_pos  = (v != '0) ? POS_SCALING_LIST : POS_END;
                end
                POS_SCALING_LIST: begin
                    if (v != '0) begin
                        res.value  = VAL_W'(1);
                        res.done   = 1'b1;
                        res.status = ST_UNSUPPORT;
                        n_halt     = 1'b1;
                    end else begin
                        n_loop = loop_inc;
                        n_pos  = (loop_inc >= IDX_W'(n_lists)) ? POS_SECOND_QP
                                                               : POS_SCALING_LIST;
                    end
                end
                POS_SECOND_QP: n_pos = POS_END;
                default: n_pos = r_pos + 1'b1;
            endcase
        end

        if (i_cmd.finish) begin
            if (!r_halt) begin
                emit       = 1'b1;
                res        = '0;
                res.code   = r_pos;
                res.index  = cur_idx;
                res.done   = 1'b1;
                res.status = ST_TRUNC;
            end
            n_pos = '0; n_lz = '0; n_acc = '0; n_loop = '0; n_gm1 = '0;
            n_map = '0; n_units = '0; n_e8 = 1'b0; n_halt = 1'b0;
            n_started = 1'b0; n_suffix = 1'b0; n_left = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_data_byte;
            r_fin  <= i_final_byte;
        end
        if (!i_rst_n) begin
            r_pos <= '0; r_lz <= '0; r_acc <= '0; r_loop <= '0; r_gm1 <= '0;
            r_map <= '0; r_units <= '0; r_e8 <= 1'b0; r_halt <= 1'b0;
            r_started <= 1'b0; r_suffix <= 1'b0; r_left <= '0;
        end else begin
            r_pos <= n_pos; r_lz <= n_lz; r_acc <= n_acc; r_loop <= n_loop;
            r_gm1 <= n_gm1; r_map <= n_map; r_units <= n_units; r_e8 <= n_e8;
            r_halt <= n_halt; r_started <= n_started; r_suffix <= n_suffix;
            r_left <= n_left;
        end
    end

    assign o_stat.emit   = emit;
    assign o_stat.res    = res;
    assign o_stat.halted = r_halt | (r_fin & 1'b0) | (r_map == 3'd7);

endmodule

// ===== rtl/pps_ctrl.sv =====
module pps_ctrl
    import pps_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  logic   i_final_byte,
    input  logic [7:0] i_data_byte,
    input  logic   i_out_ready,
    output logic   o_out_valid,
    output t_result o_out,
    output logic   o_out_last,
    output t_cmd   o_cmd,
    input  t_stat  i_stat
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_BITS   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] r_state, n_state;
    logic [2:0] r_bit, n_bit;
    logic [2:0] r_stop;
    logic       r_has_stop;
    logic       r_fin;
    logic       r_pend, n_pend;
    t_result    r_pres, n_pres;
    logic       r_ovalid, n_ovalid;
    t_result    r_ores, n_ores;
    logic       r_olast, n_olast;
    logic       step_ok;
    logic       accept;
    logic       emit_bit;
    logic       last_step;
    logic       fire;
    logic [2:0] stop_pos;

    // slot free: output register empty or being drained
    assign step_ok = !r_ovalid || i_out_ready;
    assign accept  = i_in_valid && o_in_ready;

    always_comb begin
        stop_pos = 3'd0;
        for (int k = 7; k >= 0; k--)
            if (i_data_byte[k]) stop_pos = 3'(k);
    end

    always_comb begin
        o_in_ready    = (r_state == S_IDLE) && step_ok;
        o_cmd         = '0;
        o_cmd.load    = accept;
        o_cmd.bit_sel = r_bit;
        o_cmd.is_stop = r_fin && r_has_stop && (r_bit == r_stop);
        n_state  = r_state;
        n_bit    = r_bit;
        n_pend   = r_pend;
        n_pres   = r_pres;
        n_ovalid = r_ovalid && !i_out_ready;
        n_ores   = r_ores;
        n_olast  = r_olast;
        emit_bit = 1'b0;
        fire     = 1'b0;
        last_step = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_BITS;
                    n_bit   = 3'd7;
                end
            end
            S_BITS: begin
                if (step_ok) begin
                    o_cmd.bit_en = 1'b1;
                    last_step = (r_bit == 3'd0) || i_stat.halted;
                    emit_bit  = i_stat.emit;
                    n_bit     = r_bit - 1'b1;
                    if (last_step || (i_stat.emit && i_stat.res.done))
                        n_state = r_fin ? S_FINISH : S_IDLE;
                    if (n_state != S_BITS && !r_fin) last_step = 1'b1;
                    else last_step = 1'b0;
                end
            end
            S_FINISH: begin
                if (step_ok) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                    last_step = 1'b1;
                    emit_bit = i_stat.emit;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // one result held back so last_of_run is known before it leaves
        if (emit_bit) begin
            if (r_pend) fire = 1'b1;
            n_pend = 1'b1;
            n_pres = i_stat.res;
        end
        if (last_step && (r_pend || emit_bit)) begin
            if (emit_bit && r_pend) begin
                n_ovalid = 1'b1; n_ores = r_pres; n_olast = 1'b0;
                n_pend = 1'b1;
            end else begin
                n_ovalid = 1'b1;
                n_ores   = emit_bit ? i_stat.res : r_pres;
                n_olast  = 1'b1;
                n_pend   = 1'b0;
            end
        end else if (fire) begin
            n_ovalid = 1'b1; n_ores = r_pres; n_olast = 1'b0;
        end
        if (r_state == S_IDLE && r_pend && step_ok) begin
            n_ovalid = 1'b1; n_ores = r_pres; n_olast = 1'b1; n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fin      <= i_final_byte;
            r_stop     <= stop_pos;
            r_has_stop <= (i_data_byte != 8'd0);
        end
        r_pres <= n_pres;
        r_ores <= n_ores;
        r_olast <= n_olast;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bit    <= 3'd7;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bit    <= n_bit;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_ores;
    assign o_out_last  = r_olast;

endmodule
